FILE: rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types of the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int MEDIAN_W   = 16;
    localparam int WLEN_W     = 13;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OLD,
        S_DEC,
        S_INC,
        S_RANK,
        S_EMIT
    } swm_state_t;

    typedef enum logic [1:0] {
        OP_INC,
        OP_DEC,
        OP_RANK
    } swm_op_t;

endpackage

FILE: rtl/core/swm_alu.sv
// ----------------------------------------------------------------------------
// swm_alu
// Shared count unit: node increment, node decrement, rank compare/subtract.
// ----------------------------------------------------------------------------
module swm_alu
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
    input  swm_op_t          op_i,
    input  logic [CNT_W-1:0] a_i,    // node count
    input  logic [CNT_W-1:0] b_i,    // remaining rank
    output logic [CNT_W-1:0] res_o,
    output logic             ge_o
);

    assign ge_o = (a_i >= b_i);

    always_comb begin
        case (op_i)
            OP_INC:  res_o = a_i + CNT_W'(1);
            // saturate at zero
            OP_DEC:  res_o = (a_i == '0) ? a_i : a_i - CNT_W'(1);
            OP_RANK: res_o = b_i - a_i;
            default: res_o = a_i;
        endcase
    end

endmodule

FILE: rtl/core/swm_seq.sv
// ----------------------------------------------------------------------------
// swm_seq
// Sequencer with the count tree memory and the sample delay line. Walks the
// tree one node per cycle for remove, insert and rank descent.
// ----------------------------------------------------------------------------
module swm_seq
    import swm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int PTR_W = $clog2(MAX_WINDOW),
    localparam int NODE_W = VALUE_BITS + 1,
    localparam int LVL_W = $clog2(VALUE_BITS + 2),
    localparam int TREE_DEPTH = 2 ** NODE_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  restart_i,
    input  logic [CNT_W-1:0]      len_i,
    input  logic [CNT_W-1:0]      rank_i,
    input  logic                  in_valid_i,
    output logic                  in_ready_o,
    input  logic [VALUE_BITS-1:0] in_sample_i,
    input  logic                  out_free_i,
    output logic                  res_valid_o,
    output logic [VALUE_BITS-1:0] res_value_o
);

    swm_state_t state_reg, state_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [NODE_W-1:0]     wr_node_reg, wr_node_next;
    logic [NODE_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [VALUE_BITS-1:0] sample_reg, sample_next;
    logic                  emit_reg, emit_next;
    logic [CNT_W-1:0]      rank_reg, rank_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;

    logic [CNT_W-1:0]      tree_mem [TREE_DEPTH];
    logic [CNT_W-1:0]      tree_rd_reg;
    logic                  tree_we;
    logic [NODE_W-1:0]     tree_wa, tree_ra;
    logic [CNT_W-1:0]      tree_wd;

    logic [VALUE_BITS-1:0] win_mem [MAX_WINDOW];
    logic [VALUE_BITS-1:0] win_rd_reg;
    logic                  win_we, win_re;
    logic [PTR_W-1:0]      old_pos;
    logic [CNT_W:0]        wp_ext, len_ext, pos_sum;

    swm_op_t               alu_op;
    logic [CNT_W-1:0]      alu_res;
    logic                  alu_ge;
    logic [NODE_W-1:0]     node_step;

    swm_alu #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_alu (
        .op_i  (alu_op),
        .a_i   (tree_rd_reg),
        .b_i   (rank_reg),
        .res_o (alu_res),
        .ge_o  (alu_ge)
    );

    // oldest sample sits len entries behind the write pointer
    always_comb begin
        wp_ext  = (CNT_W + 1)'(wp_reg);
        len_ext = {1'b0, len_i};
        if (wp_ext >= len_ext) begin
            pos_sum = wp_ext - len_ext;
        end else begin
            pos_sum = wp_ext + (CNT_W + 1)'(MAX_WINDOW) - len_ext;
        end
        old_pos = pos_sum[PTR_W-1:0];
    end

    assign node_step   = {node_reg[NODE_W-2:0], ~alu_ge};
    assign res_value_o = node_reg[VALUE_BITS-1:0];

    always_comb begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        node_next     = node_reg;
        wr_node_next  = wr_node_reg;
        clr_addr_next = clr_addr_reg;
        sample_next   = sample_reg;
        emit_next     = emit_reg;
        rank_next     = rank_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        tree_we       = 1'b0;
        tree_wa       = wr_node_reg;
        tree_wd       = alu_res;
        tree_ra       = node_reg;
        win_we        = 1'b0;
        win_re        = 1'b0;
        in_ready_o    = 1'b0;
        res_valid_o   = 1'b0;
        alu_op        = OP_RANK;

        case (state_reg)
            S_CLEAR: begin
                tree_we       = 1'b1;
                tree_wa       = clr_addr_reg;
                tree_wd       = '0;
                clr_addr_next = clr_addr_reg + NODE_W'(1);
                if (clr_addr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready_o = 1'b1;
                if (in_valid_i) begin
                    sample_next = in_sample_i;
                    win_we      = 1'b1;
                    win_re      = 1'b1;
                    wp_next     = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                                     : wp_reg + PTR_W'(1);
                    lvl_next    = '0;
                    if (fill_reg >= len_i) begin
                        emit_next  = 1'b1;
                        state_next = S_OLD;
                    end else begin
                        fill_next  = fill_reg + CNT_W'(1);
                        emit_next  = (fill_reg + CNT_W'(1) == len_i);
                        node_next  = {1'b1, in_sample_i};
                        state_next = S_INC;
                    end
                end
            end
            S_OLD: begin
                node_next  = {1'b1, win_rd_reg};
                lvl_next   = '0;
                state_next = S_DEC;
            end
            S_DEC, S_INC: begin
                alu_op = (state_reg == S_DEC) ? OP_DEC : OP_INC;
                // write back the node read in the previous cycle
                if (lvl_reg != '0) begin
                    tree_we = 1'b1;
                end
                wr_node_next = node_reg;
                node_next    = node_reg >> 1;
                lvl_next     = lvl_reg + LVL_W'(1);
                if (lvl_reg == LVL_W'(VALUE_BITS + 1)) begin
                    lvl_next = '0;
                    if (state_reg == S_DEC) begin
                        node_next  = {1'b1, sample_reg};
                        state_next = S_INC;
                    end else if (emit_reg) begin
                        node_next  = NODE_W'(1);
                        rank_next  = rank_i;
                        state_next = S_RANK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RANK: begin
                alu_op = OP_RANK;
                if (lvl_reg == '0) begin
                    tree_ra  = {node_reg[NODE_W-2:0], 1'b0};
                    lvl_next = LVL_W'(1);
                end else begin
                    // go left when the left count covers the rank
                    node_next = node_step;
                    if (!alu_ge) begin
                        rank_next = alu_res;
                    end
                    tree_ra  = {node_step[NODE_W-2:0], 1'b0};
                    lvl_next = lvl_reg + LVL_W'(1);
                    if (lvl_reg == LVL_W'(VALUE_BITS)) begin
                        lvl_next   = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free_i) begin
                    res_valid_o = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (restart_i) begin
            state_next    = S_CLEAR;
            clr_addr_next = '0;
            wp_next       = '0;
            fill_next     = '0;
            lvl_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            lvl_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            lvl_reg      <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        wr_node_reg <= wr_node_next;
        sample_reg  <= sample_next;
        emit_reg    <= emit_next;
        rank_reg    <= rank_next;
    end

    always_ff @(posedge aclk) begin
        if (tree_we) begin
            tree_mem[tree_wa] <= tree_wd;
        end
        tree_rd_reg <= tree_mem[tree_ra];
    end

    // read before write: the oldest entry may share the write address
    always_ff @(posedge aclk) begin
        if (win_re) begin
            win_rd_reg <= win_mem[old_pos];
        end
        if (win_we) begin
            win_mem[wp_reg] <= in_sample_i;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_i)
        else $error("fill count above window length");

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W + 1)'(wp_reg) < (CNT_W + 1)'(MAX_WINDOW))
        else $error("write pointer out of range");

    a_emit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_o |-> fill_reg == len_i)
        else $error("median emitted before window filled");

    a_remove_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OLD |-> fill_reg == len_i)
        else $error("removal started on a partial window");

endmodule

FILE: rtl/core/sliding_window_median_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running lower median over the last window_length samples, kept as a
// binary count tree over the value range plus a circular sample line.
//
//   channel   dir   payload                      handshake
//   s_        in    sample  (s_tdata[15:0])      s_tvalid / s_tready
//   m_        out   median  (m_tdata[15:0])      m_tvalid / m_tready
//   cfg_      in    window_length (13 bits)      cfg_wr_en, no wait
//
// While the window fills a sample is only inserted; the sample that completes
// it is inserted and ranked, and once full each sample removes the oldest,
// inserts and ranks. The count memory walks one node per cycle.
// After reset and after each window_length write a clearing pass runs over
// every entry of the count memory; s_tready stays low meanwhile.
// A result held in the output register stalls the unit only at its next emit.
// ----------------------------------------------------------------------------
module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,     // [15:0] sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [MEDIAN_W-1:0] m_tdata,     // [15:0] median
    input  logic                cfg_wr_en,
    input  logic [WLEN_W-1:0]   cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [WLEN_W-1:0]     wlen_reg;
    logic [CNT_W-1:0]      len;
    logic [CNT_W:0]        rank_sum;
    logic [CNT_W-1:0]      rank;
    logic                  out_free;
    logic                  res_valid;
    logic [VALUE_BITS-1:0] res_value;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [MEDIAN_W-1:0]   m_tdata_reg, m_tdata_next;

    // clamp the length to 1 .. MAX_WINDOW
    always_comb begin
        if (wlen_reg == '0) begin
            len = CNT_W'(1);
        end else if (32'(wlen_reg) > 32'(MAX_WINDOW)) begin
            len = CNT_W'(MAX_WINDOW);
        end else begin
            len = CNT_W'(wlen_reg);
        end
        rank_sum = {1'b0, len} + (CNT_W + 1)'(1);
        rank     = rank_sum[CNT_W:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
        end else if (cfg_wr_en) begin
            wlen_reg <= cfg_wr_data;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    swm_seq #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart_i   (cfg_wr_en),
        .len_i       (len),
        .rank_i      (rank),
        .in_valid_i  (s_tvalid),
        .in_ready_o  (s_tready),
        .in_sample_i (VALUE_BITS'(s_tdata)),
        .out_free_i  (out_free),
        .res_valid_o (res_valid),
        .res_value_o (res_value)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = MEDIAN_W'(res_value);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the running lower median of sliding_window_median_unit against a
// histogram-tree predictor kept in the bench. Covers the default window,
// windows of one and zero, a random even window under three pacing
// patterns, and long windows, set directly and by clamping, that stay in
// their filling phase and must produce no median.
// ----------------------------------------------------------------------------
module tb_top
    import swm_pkg::*;
();

    localparam int LEAVES         = 1 << VALUE_BITS_DEF;
    localparam int RING_DEPTH     = MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES  = 2 * (3 * VALUE_BITS_DEF + 8);
    // the clearing pass is the longest quiet stretch of a correct run
    localparam int WATCHDOG_LIMIT = 4 * (1 << (VALUE_BITS_DEF + 1));
    localparam logic [WLEN_W-1:0] WLEN_FULL     = WLEN_W'(MAX_WINDOW_DEF);
    localparam logic [WLEN_W-1:0] WLEN_ALL_ONES = '1;
    localparam int LONG_WINDOW_SAMPLES = 20;

    localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLES [21] = '{
        16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF,
        16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'd100,
        16'd100,  16'd100,  16'd3,    16'd2,    16'd1,    16'd4,    16'd6
    };

    typedef enum int {
        PACE_RX_SLOW,   // sender idles 8 in 100, receiver stalls 65 in 100
        PACE_TX_SLOW,   // the other way round
        PACE_FULL       // neither side idles
    } pacing_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata     = '0;     // [15:0] sample
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [MEDIAN_W-1:0] m_tdata;              // [15:0] median
    logic                cfg_wr_en   = 1'b0;
    logic [WLEN_W-1:0]   cfg_wr_data = '0;

    sliding_window_median_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // histogram tree over the sample range plus the delay line of the window
    int unsigned         hist_tree [2*LEAVES];
    logic [SAMPLE_W-1:0] sample_ring [RING_DEPTH];
    int unsigned         ring_ptr;
    int unsigned         ring_fill;
    logic [WLEN_W-1:0]   window_cfg;
    logic [MEDIAN_W-1:0] median_expected [$];

    int          send_idle_pct;
    int          recv_stall_pct;
    int          err_count       = 0;
    int          samples_sent    = 0;
    int          medians_checked = 0;
    int          idle_cycles     = 0;
    logic [SAMPLE_W-1:0] cluster_base = '0;
    string       windows_used    = "3";

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    function automatic void restart_prediction();
        for (int i = 0; i < 2 * LEAVES; i++) hist_tree[i] = 0;
        for (int i = 0; i < RING_DEPTH; i++) sample_ring[i] = '0;
        ring_ptr  = 0;
        ring_fill = 0;
    endfunction

    function automatic int unsigned effective_window();
        if (window_cfg == 0) return 1;
        if (window_cfg > RING_DEPTH) return RING_DEPTH;
        return window_cfg;
    endfunction

    function automatic void hist_adjust(input logic [SAMPLE_W-1:0] v, input bit up);
        int unsigned node;
        node = LEAVES + v;
        while (node >= 1) begin
            if (up) hist_tree[node]++;
            else if (hist_tree[node] > 0) hist_tree[node]--;
            node = node >> 1;
        end
    endfunction

    // descend from the root toward the leaf holding the given rank
    function automatic logic [SAMPLE_W-1:0] hist_select(input int unsigned rank);
        int unsigned node;
        int unsigned r;
        node = 1;
        r    = rank;
        while (node < LEAVES) begin
            if (hist_tree[2*node] >= r) begin
                node = 2 * node;
            end else begin
                r    = r - hist_tree[2*node];
                node = 2 * node + 1;
            end
        end
        return SAMPLE_W'(node - LEAVES);
    endfunction

    function automatic void predict_median(input logic [SAMPLE_W-1:0] v);
        int unsigned span;
        int unsigned oldest;
        span = effective_window();
        if (ring_fill >= span) begin
            oldest = (ring_ptr + RING_DEPTH - span) % RING_DEPTH;
            hist_adjust(sample_ring[oldest], 1'b0);
        end else begin
            ring_fill++;
        end
        hist_adjust(v, 1'b1);
        sample_ring[ring_ptr] = v;
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        if (ring_fill >= span)
            median_expected = {median_expected, hist_select((span + 1) / 2)};
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return $urandom_range(0, 1) ? '1 : '0;
        if (pick < 5) return SAMPLE_W'($urandom);
        // clustered values give repeats and close ranks
        if ($urandom_range(0, 31) == 0) cluster_base = SAMPLE_W'($urandom);
        return cluster_base + SAMPLE_W'($urandom_range(0, 15));
    endfunction

    function automatic void set_pacing(input pacing_t pace);
        case (pace)
            PACE_RX_SLOW: begin
                send_idle_pct  = 8;
                recv_stall_pct = 65;
            end
            PACE_TX_SLOW: begin
                send_idle_pct  = 65;
                recv_stall_pct = 8;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // the sample request is taken at the edge where valid and ready are both high
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        predict_median(v);
    endtask

    // hold the sender until every pending median is out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (median_expected.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        window_cfg   = len;
        restart_prediction();
        windows_used = {windows_used, $sformatf(" %0d", len)};
    endtask

    always @(posedge aclk) begin : median_check
        logic [MEDIAN_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            medians_checked++;
            if (median_expected.size() == 0) begin
                report_mismatch($sformatf("median %0d with none pending", m_tdata));
            end else begin
                want = median_expected.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("median got %0d, want %0d", m_tdata, want));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no request moved for %0d cycles", $time, idle_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // extremes, repeats, ascending and descending runs at the reset window of 3
    task automatic test_directed_default();
        set_pacing(PACE_RX_SLOW);
        foreach (DIRECTED_SAMPLES[i]) send_sample(DIRECTED_SAMPLES[i]);
        settle();
    endtask

    task automatic test_unit_window();
        write_window(WLEN_W'(1));
        for (int i = 0; i < 80; i++) begin
            send_sample(next_sample());
            if (i == 40) hold_until_drained();
        end
        settle();
    endtask

    // a length of zero behaves as a window of one
    task automatic test_zero_window();
        write_window('0);
        for (int i = 0; i < 60; i++) send_sample(next_sample());
        settle();
    endtask

    // even length exercises the lower of the two middle values
    task automatic test_even_window();
        write_window(WLEN_W'(2 * $urandom_range(1, 32)));
        for (int part = 0; part < 3; part++) begin
            set_pacing(pacing_t'(part));
            for (int i = 0; i < 250; i++) begin
                send_sample(next_sample());
                if ((part == 0 && i == 100) || $urandom_range(0, 149) == 0)
                    hold_until_drained();
            end
        end
        settle();
    endtask

    // a long window only starts to fill here: no median may appear
    task automatic test_long_window(input logic [WLEN_W-1:0] len);
        set_pacing(PACE_FULL);
        write_window(len);
        for (int i = 0; i < LONG_WINDOW_SAMPLES; i++) send_sample(next_sample());
        settle();
    endtask

    initial begin
        window_cfg = WLEN_RESET;
        restart_prediction();
        set_pacing(PACE_RX_SLOW);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_default();
        test_unit_window();
        test_zero_window();
        test_even_window();
        test_long_window(WLEN_ALL_ONES);
        test_long_window(WLEN_FULL);

        if (median_expected.size() != 0)
            report_mismatch($sformatf("%0d medians never delivered", median_expected.size()));
        $display("Sent %0d samples and checked %0d medians over window lengths %s.",
                 samples_sent, medians_checked, windows_used);
        $display("Pacing went from slow receiver to slow sender to full rate; %0d errors.",
                 err_count);
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
